// ===== rtl/ring_buffer_deque_unit_assert.svh =====
// Assertion macros shared by the deque RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef RING_BUFFER_DEQUE_UNIT_ASSERT_SVH
`define RING_BUFFER_DEQUE_UNIT_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define RBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define RBD_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/rbd_pkg.sv =====
// Shared types, codes and defaults for the ring buffer deque.
// No dependencies.
package rbd_pkg;

    localparam int DEPTH_DEF      = 512;
    localparam int DATA_WIDTH_DEF = 32;

    // capacity register
    localparam int          CAP_W     = 10;
    localparam logic [9:0]  CAP_RESET = 10'd512;
    localparam int          APB_AW    = 3;
    localparam int          APB_DW    = 32;
    localparam logic        REG_CAPACITY = 1'b0;   // register index, paddr[2]

    // request codes
    localparam logic [1:0] REQ_INS_REAR  = 2'd0;
    localparam logic [1:0] REQ_INS_FRONT = 2'd1;
    localparam logic [1:0] REQ_REM_REAR  = 2'd2;
    localparam logic [1:0] REQ_REM_FRONT = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    // per-beat result flags from the control unit
    typedef struct packed {
        status_t status;
        logic    is_empty;
        logic    is_full;
        logic    has_data;   // remove that read the store
    } rbd_flags_t;

endpackage

// ===== rtl/rbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/rbd_ctrl.sv =====
// Deque control: front/rear indexes, item count, store access per beat.
// Depends on rbd_pkg and ring_buffer_deque_unit_assert.svh.
`include "ring_buffer_deque_unit_assert.svh"

module rbd_ctrl #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [1:0]              req_type,
    input  logic [DATA_WIDTH-1:0]   data_in,
    input  logic [rbd_pkg::CAP_W-1:0] capacity,
    output logic                    mem_we,
    output logic [IDX_W-1:0]        mem_waddr,
    output logic [DATA_WIDTH-1:0]   mem_wdata,
    output logic                    mem_re,
    output logic [IDX_W-1:0]        mem_raddr,
    output logic [CNT_W-1:0]        occupancy,
    output rbd_pkg::rbd_flags_t     flags
);

    localparam int CMP_W = (CNT_W > rbd_pkg::CAP_W) ? CNT_W : rbd_pkg::CAP_W;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [CMP_W-1:0] cap_w;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] cap_m1;
    logic             is_insert;
    logic             is_rear;

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] lim);
        logic [IDX_W-1:0] r;
        if (CNT_W'(i) >= lim)
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] lim);
        logic [IDX_W-1:0] r;
        if (i == '0)
            r = lim[IDX_W-1:0];
        else
            r = i - 1'b1;
        return r;
    endfunction

    // capacity clamped to 1..DEPTH
    always_comb
    begin
        cap_w = CMP_W'(capacity);
        if (cap_w == '0)
            cap_eff = CNT_W'(1);
        else if (cap_w > CMP_W'(DEPTH))
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = cap_w[CNT_W-1:0];
        cap_m1 = cap_eff - 1'b1;
    end

    assign is_insert = (req_type == rbd_pkg::REQ_INS_REAR) ||
                       (req_type == rbd_pkg::REQ_INS_FRONT);
    assign is_rear   = (req_type == rbd_pkg::REQ_INS_REAR) ||
                       (req_type == rbd_pkg::REQ_REM_REAR);
    assign mem_wdata = data_in;

    always_comb
    begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_re         = 1'b0;
        mem_raddr      = is_rear ? rear_reg : front_reg;
        flags.status   = rbd_pkg::ST_OK;
        flags.has_data = 1'b0;
        if (is_insert)
        begin
            if (count_reg >= cap_eff)
            begin
                flags.status = rbd_pkg::ST_OVERFLOW;
            end
            else
            begin
                if (count_reg == '0)
                begin
                    front_next = '0;
                    rear_next  = '0;
                    mem_waddr  = '0;
                end
                else if (is_rear)
                begin
                    rear_next = idx_up(rear_reg, cap_m1);
                    mem_waddr = rear_next;
                end
                else
                begin
                    front_next = idx_down(front_reg, cap_m1);
                    mem_waddr  = front_next;
                end
                mem_we     = accept;
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                flags.status = rbd_pkg::ST_UNDERFLOW;
            end
            else
            begin
                mem_re         = accept;
                flags.has_data = 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    front_next = '0;
                    rear_next  = '0;
                end
                else if (is_rear)
                begin
                    rear_next = idx_down(rear_reg, cap_m1);
                end
                else
                begin
                    front_next = idx_up(front_reg, cap_m1);
                end
                count_next = count_reg - 1'b1;
            end
        end
        occupancy      = count_next;
        flags.is_empty = (count_next == '0);
        flags.is_full  = (count_next >= cap_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    `RBD_NEVER(a_one_access, mem_we && mem_re, "store read and written in one beat")
    `RBD_ASSERT(a_empty_idx, (count_reg == '0) |-> (front_reg == '0 && rear_reg == '0),
                "indexes not at zero while deque empty")
    `RBD_ASSERT(a_ins_count, (accept && mem_we) |=> (count_reg == $past(count_reg) + 1'b1),
                "accepted insert did not bump the count")

endmodule

// ===== rtl/ring_buffer_deque_unit.sv =====
// Top level of the ring buffer deque: APB capacity register, result pipeline.
// Depends on rbd_pkg, rbd_ram, rbd_ctrl and ring_buffer_deque_unit_assert.svh.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------
//  request   | in        | in_valid/in_ready  | req_type, data_in
//  result    | out       | out_valid/out_ready| data_out, status, occupancy,
//            |           |                    | is_empty, is_full
//  config    | in        | APB, pready=1      | capacity at byte address 0
//
// One request beat per cycle sustained while in_ready stays high. The store read
// fires on the request beat's own edge; the beat waits in the pending stage and
// then loads the output register, which drives out_valid.
// A stalled result holds the pending stage; in_ready drops only when both
// the pending stage and the output register are full and out_ready is low.
// Reset clears indexes, count and valid flags, capacity to 512; store kept.
`include "ring_buffer_deque_unit_assert.svh"

module ring_buffer_deque_unit #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [DATA_WIDTH-1:0]       data_in,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [DATA_WIDTH-1:0]       data_out,
    output logic [1:0]                  status,
    output logic [CNT_W-1:0]            occupancy,
    output logic                        is_empty,
    output logic                        is_full,
    // APB config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbd_pkg::APB_AW-1:0]  paddr,
    input  logic [rbd_pkg::APB_DW-1:0]  pwdata,
    output logic [rbd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [rbd_pkg::CAP_W-1:0] capacity_reg;

    // request beat and control outputs
    logic                  accept;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [CNT_W-1:0]      ctrl_occ;
    rbd_pkg::rbd_flags_t   ctrl_flags;

    // pending stage: waits for the store read
    logic                  pend_valid_reg;
    logic [CNT_W-1:0]      pend_occ_reg;
    rbd_pkg::rbd_flags_t   pend_flags_reg;
    logic                  pend_move;

    // output register
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] data_out_reg;
    logic [1:0]            status_reg;
    logic [CNT_W-1:0]      occ_reg;
    logic                  empty_reg;
    logic                  full_reg;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rbd_pkg::REG_CAPACITY) ?
                    rbd_pkg::APB_DW'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= rbd_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rbd_pkg::REG_CAPACITY))
        begin
            capacity_reg <= pwdata[rbd_pkg::CAP_W-1:0];
        end
    end

    // ---------------- flow control ----------------
    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;
    assign accept    = in_valid && in_ready;

    rbd_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .data_in   (data_in),
        .capacity  (capacity_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .occupancy (ctrl_occ),
        .flags     (ctrl_flags)
    );

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- pending stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_occ_reg   <= ctrl_occ;
            pend_flags_reg <= ctrl_flags;
        end
    end

    // ---------------- output register ----------------
    // read data holds until the next accepted remove, which can only
    // land on the same edge that moves this beat forward
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            data_out_reg <= pend_flags_reg.has_data ? mem_rdata : '0;
            status_reg   <= pend_flags_reg.status;
            occ_reg      <= pend_occ_reg;
            empty_reg    <= pend_flags_reg.is_empty;
            full_reg     <= pend_flags_reg.is_full;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;
    assign is_empty  = empty_reg;
    assign is_full   = full_reg;

    `RBD_ASSERT(a_stall_blocks, (pend_valid_reg && out_valid_reg && !out_ready) |-> !in_ready,
                "request taken while both result stages are stalled")
    `RBD_ASSERT(a_pend_to_out, pend_move |=> out_valid_reg,
                "pending beat did not reach the output register")
    `RBD_ASSERT(a_uflow_zero,
                (out_valid_reg && status_reg == rbd_pkg::ST_UNDERFLOW) |-> (data_out_reg == '0),
                "underflow result carries data")

endmodule

// ===== tb/sv/ring_buffer_deque_unit_tb.sv =====
// Self-checking testbench for ring_buffer_deque_unit: directed and random deque requests.
// Depends on rbd_pkg and the ring_buffer_deque_unit RTL; predicts every result in-house.
module ring_buffer_deque_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = rbd_pkg::DEPTH_DEF;
    localparam int DW        = rbd_pkg::DATA_WIDTH_DEF;
    localparam int CAP_W     = rbd_pkg::CAP_W;
    localparam int APB_AW    = rbd_pkg::APB_AW;
    localparam int APB_DW    = rbd_pkg::APB_DW;
    // result passes the pending stage and the output register; give it a margin
    localparam int SETTLE    = 4;
    // longest legal quiet stretch is a long gap or stall plus a config
    // access; this is several times that
    localparam int QUIET_LIMIT = 4000;
    localparam logic [APB_AW-1:0] CAP_ADDR = APB_AW'(4 * rbd_pkg::REG_CAPACITY);

    typedef struct packed {
        logic [DW-1:0]    data;
        rbd_pkg::status_t status;
        logic [CAP_W-1:0] occ;
        logic             empty;
        logic             full;
    } deque_result_t;

    // Shadow deque: indexes, count, capacity and store, plus the queue of
    // results still owed by the block.
    class deque_scoreboard;
        logic [DW-1:0]    slot [NUM_SLOTS];
        bit               slot_written [NUM_SLOTS];
        int               head_idx;
        int               tail_idx;
        int               held;
        logic [CAP_W-1:0] cap_reg;
        deque_result_t    awaiting [$];
        int               errors;

        function new();
            head_idx = 0;
            tail_idx = 0;
            held     = 0;
            cap_reg  = rbd_pkg::CAP_RESET;
            errors   = 0;
            foreach (slot_written[i]) slot_written[i] = 1'b0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            cap_reg = cap;
        endfunction

        // 0 behaves as 1, anything past the store size as the store size
        function int eff_cap();
            int c;
            c = cap_reg;
            if (c == 0) c = 1;
            if (c > NUM_SLOTS) c = NUM_SLOTS;
            return c;
        endfunction

        function int step_up(int i, int cap);
            return (i >= cap - 1) ? 0 : i + 1;
        endfunction

        function int step_down(int i, int cap);
            return (i == 0) ? cap - 1 : i - 1;
        endfunction

        function int pending();
            return awaiting.size();
        endfunction

        // a remove must never hit a store entry that was never written
        function bit remove_safe(logic [1:0] req);
            if (held == 0) return 1'b1;
            return slot_written[(req == rbd_pkg::REQ_REM_REAR) ? tail_idx : head_idx];
        endfunction

        function void note_request(logic [1:0] req, logic [DW-1:0] din);
            int            cap;
            int            wr_idx;
            deque_result_t r;
            cap      = eff_cap();
            r.data   = '0;
            r.status = rbd_pkg::ST_OK;
            if (req == rbd_pkg::REQ_INS_REAR || req == rbd_pkg::REQ_INS_FRONT)
            begin
                if (held >= cap)
                begin
                    r.status = rbd_pkg::ST_OVERFLOW;
                end
                else
                begin
                    if (held == 0)
                    begin
                        head_idx = 0;
                        tail_idx = 0;
                    end
                    else if (req == rbd_pkg::REQ_INS_REAR)
                    begin
                        tail_idx = step_up(tail_idx, cap);
                    end
                    else
                    begin
                        head_idx = step_down(head_idx, cap);
                    end
                    wr_idx = (req == rbd_pkg::REQ_INS_REAR) ? tail_idx : head_idx;
                    slot[wr_idx]         = din;
                    slot_written[wr_idx] = 1'b1;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    r.status = rbd_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    r.data = slot[(req == rbd_pkg::REQ_REM_REAR) ? tail_idx : head_idx];
                    if (held == 1)
                    begin
                        head_idx = 0;
                        tail_idx = 0;
                    end
                    else if (req == rbd_pkg::REQ_REM_REAR)
                    begin
                        tail_idx = step_down(tail_idx, cap);
                    end
                    else
                    begin
                        head_idx = step_up(head_idx, cap);
                    end
                    held--;
                end
            end
            r.occ   = CAP_W'(held);
            r.empty = (held == 0);
            r.full  = (held >= cap);
            awaiting.push_back(r);
        endfunction

        function void check_result(logic [DW-1:0] data, rbd_pkg::status_t st,
                                   logic [CAP_W-1:0] occ, logic empty, logic full);
            deque_result_t e;
            if (awaiting.size() == 0)
            begin
                $display("%0t: unexpected result beat: data_out %h status %0d occupancy %0d",
                         $time, data, st, occ);
                errors++;
                return;
            end
            e = awaiting.pop_front();
            if (data !== e.data)
            begin
                $display("%0t: data_out mismatch: expected %h, actual %h", $time, e.data, data);
                errors++;
            end
            if (st !== e.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
                errors++;
            end
            if (occ !== e.occ)
            begin
                $display("%0t: occupancy mismatch: expected %0d, actual %0d", $time, e.occ, occ);
                errors++;
            end
            if (empty !== e.empty)
            begin
                $display("%0t: is_empty mismatch: expected %b, actual %b", $time, e.empty, empty);
                errors++;
            end
            if (full !== e.full)
            begin
                $display("%0t: is_full mismatch: expected %b, actual %b", $time, e.full, full);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = rbd_pkg::REQ_INS_REAR;
    logic [DW-1:0]      data_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DW-1:0]      data_out;
    logic [1:0]         status;
    logic [CAP_W-1:0]   occupancy;
    logic               is_empty;
    logic               is_full;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // per-phase "no idling" switches for the request and result sides
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;

    deque_scoreboard sb = new();

    ring_buffer_deque_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .status    (status),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Insert with probability ins_pct percent, side chosen at random.
    function automatic logic [1:0] pick_req(int ins_pct);
        if ($urandom_range(0, 99) < ins_pct)
            return ($urandom_range(0, 1) != 0) ? rbd_pkg::REQ_INS_FRONT : rbd_pkg::REQ_INS_REAR;
        return ($urandom_range(0, 1) != 0) ? rbd_pkg::REQ_REM_FRONT : rbd_pkg::REQ_REM_REAR;
    endfunction

    // One request beat. Entered right after a rising edge; returns at the
    // edge where the beat was taken. valid is only lowered when a gap
    // follows, so it never toggles twice in one step.
    task automatic send_req(logic [1:0] req, logic [DW-1:0] din);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        data_in  <= din;
        do @(posedge clk); while (!in_ready);
        sb.note_request(req, din);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_capacity_reg(logic [CAP_W-1:0] cap);
        logic [APB_DW-1:0] rd;
        apb_read(CAP_ADDR, rd);
        if (rd !== APB_DW'(cap))
        begin
            $display("%0t: capacity readback mismatch: expected %h, actual %h",
                     $time, APB_DW'(cap), rd);
            sb.errors++;
        end
    endtask

    // Register change only with the block idle: no requests in flight and
    // every result collected. The deque itself may still hold items.
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        // upper bits of pwdata carry junk; only the low field may stick
        apb_write(CAP_ADDR, ($urandom() & ~32'h3FF) | APB_DW'(cap));
        sb.set_capacity(cap);
        @(posedge clk);
        check_capacity_reg(cap);
    endtask

    // Random requests in segments that lean toward filling, then draining,
    // so that full and empty are both reached for small capacities.
    task automatic random_items(int count, int ins_hi, int ins_lo);
        int         seg;
        int         pct;
        logic [1:0] req;
        seg = 0;
        pct = ins_lo;
        for (int i = 0; i < count; i++)
        begin
            if (seg == 0)
            begin
                seg = $urandom_range(4, 14);
                pct = (pct == ins_hi) ? ins_lo : ins_hi;
            end
            seg--;
            req = pick_req(pct);
            // steer away from entries the store never saw
            if (!sb.remove_safe(req))
                req = (req == rbd_pkg::REQ_REM_REAR) ? rbd_pkg::REQ_INS_REAR
                                                     : rbd_pkg::REQ_INS_FRONT;
            send_req(req, $urandom());
        end
    endtask

    // Result side: check every beat taken, then decide ready for the next
    // cycle. One nonblocking write of out_ready per edge.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(data_out, status, occupancy, is_empty, is_full);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap(out_calm);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    stall--;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: too many cycles with no beat on any port ends the run.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        int small_caps [9];
        small_caps = '{1, 0, 2, 5, 1023, 16, 600, 7, 0};
        small_caps[8] = $urandom_range(1, 40);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_capacity_reg(rbd_pkg::CAP_RESET);

        // --- directed: empty deque at reset capacity
        send_req(rbd_pkg::REQ_REM_REAR, 32'h1234_5678);      // underflow
        send_req(rbd_pkg::REQ_REM_FRONT, 32'hFFFF_FFFF);     // underflow
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0000_0000);      // first item lands at entry 0
        send_req(rbd_pkg::REQ_INS_FRONT, 32'hFFFF_FFFF);     // front wraps down to the top
        send_req(rbd_pkg::REQ_INS_REAR, 32'h5A5A_5A5A);
        send_req(rbd_pkg::REQ_REM_FRONT, 32'h0);             // front wraps back up to 0
        send_req(rbd_pkg::REQ_REM_REAR, 32'h0);
        send_req(rbd_pkg::REQ_REM_REAR, 32'hDEAD_BEEF);      // last item, indexes back to 0
        send_req(rbd_pkg::REQ_REM_FRONT, 32'h0);             // underflow again

        // capacity 1: one insert fills it
        set_capacity(10'd1);
        send_req(rbd_pkg::REQ_INS_FRONT, 32'hA5A5_A5A5);
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0F0F_0F0F);      // overflow, nothing written
        send_req(rbd_pkg::REQ_REM_REAR, 32'h0);

        // capacity 0 behaves as 1
        set_capacity(10'd0);
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0000_0001);
        send_req(rbd_pkg::REQ_INS_FRONT, 32'h0000_0002);     // overflow
        send_req(rbd_pkg::REQ_REM_FRONT, 32'h0);

        // capacity 2: rear wraps at capacity minus one
        set_capacity(10'd2);
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0000_0003);
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0000_0004);
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0000_0005);      // overflow
        send_req(rbd_pkg::REQ_REM_FRONT, 32'h0);
        send_req(rbd_pkg::REQ_INS_REAR, 32'h0000_0006);      // rear 1 -> 0
        send_req(rbd_pkg::REQ_REM_FRONT, 32'h0);
        send_req(rbd_pkg::REQ_REM_REAR, 32'h0);

        // --- random: fill the full store until it overflows
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        set_capacity(10'd512);
        random_items(570, 95, 95);

        // shrink hard with the store full, then drain through the small window
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        set_capacity(10'd3);
        random_items(570, 10, 10);

        // assorted capacities, changed while items may still be held
        foreach (small_caps[i])
        begin
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            set_capacity(CAP_W'(small_caps[i]));
            random_items(45, 75, 25);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
